// ----- hdl/sqe_pkg.sv -----
// shared types and constants of the segment to quad expander
package sqe_pkg;

  localparam int NODE_DEPTH = 4096;
  localparam int NODE_AW    = $clog2(NODE_DEPTH);
  localparam int IDX_W      = 12;
  localparam int IN_W       = 152;
  localparam int OUT_W      = 112;
  localparam int KW         = 17;
  localparam int ROOT_STEPS = KW;
  localparam int WW         = 101;

  localparam logic ACT_STORE = 1'b0;
  localparam logic ACT_EDGE  = 1'b1;

  // one lane of the bit-serial root search: largest k with k*k*sq <= t
  typedef struct packed {
    logic [WW-1:0] t;
    logic [WW-1:0] p;   // k*k*sq
    logic [WW-1:0] r;   // k*sq
    logic [KW-1:0] k;
  } lane_t;

  typedef struct packed {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] qx;
    logic signed [31:0] qy;
    logic [31:0]        pz;
    logic [31:0]        qz;
    logic [7:0]         green;
    logic               negx;
    logic               negy;
    logic               zero;
  } carry_t;

  typedef struct packed {
    lane_t       lx;
    lane_t       ly;
    logic [65:0] sq;
    carry_t      c;
  } step_t;

endpackage

// ----- hdl/segment_to_quad_expander_unit.sv -----
// top level of the segment to quad expander
// path: stage 0 table read, stages 1 to 4, the root steps, then the serializer
// throughput: one corner a cycle while m_tready is high, edges set by the four corner
//   transfers; with en high the input takes one store or edge a cycle
// the offset search runs as 17 pipelined root steps, one result bit per stage
// reset: synchronous rst clears valid bits and serializer state; node table is not cleared
module segment_to_quad_expander_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // node_index[11:0] coord_x[43:12] coord_y[75:44] coord_z[107:76]
  // end_a[119:108] end_b[131:120] width[147:132], zero fill above
  input  logic [sqe_pkg::IN_W-1:0]   s_tdata,
  // action
  input  logic                       s_tuser,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // corner_x[31:0] corner_y[63:32] corner_z[95:64] green[103:96]
  // corner_number[105:104], zero fill above
  output logic [sqe_pkg::OUT_W-1:0]  m_tdata,
  // last_corner
  output logic                       m_tlast
);

  logic        en, accept, can_load;
  logic [31:0] a_x, a_y, a_z, b_x, b_y, b_z;

  // stage registers
  logic        v0, v1, v2, v3, v4;
  logic [15:0] w0, w1;
  logic signed [32:0] dx, dy;
  logic [31:0] adx1, ady1;
  logic [63:0] adx2, ady2;
  logic [31:0] ww2;
  logic [65:0] sq3;
  logic [63:0] px_lo, px_hi, py_lo, py_hi;
  sqe_pkg::carry_t c1, c2, c3;
  sqe_pkg::step_t  s4;
  logic [22:0] shade;
  logic [7:0]  green_c;

  sqe_pkg::step_t chain_d [sqe_pkg::ROOT_STEPS + 1];
  logic           chain_v [sqe_pkg::ROOT_STEPS + 1];

  // whole pipeline moves when its last stage is empty or the serializer can take it
  assign en       = !chain_v[sqe_pkg::ROOT_STEPS] || can_load;
  assign s_tready = en;
  assign accept   = s_tvalid && s_tready;

  sqe_node_table u_table (
    .clk      (clk),
    .en       (en),
    .wr       (accept && (s_tuser == sqe_pkg::ACT_STORE)),
    .wr_idx   (s_tdata[11:0]),
    .wr_x     (s_tdata[43:12]),
    .wr_y     (s_tdata[75:44]),
    .wr_z     (s_tdata[107:76]),
    .rd_a_idx (s_tdata[119:108]),
    .rd_b_idx (s_tdata[131:120]),
    .a_x      (a_x),
    .a_y      (a_y),
    .a_z      (a_z),
    .b_x      (b_x),
    .b_y      (b_y),
    .b_z      (b_z)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (en) begin
      v0 <= accept && (s_tuser == sqe_pkg::ACT_EDGE);
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // green shade: trunc(100*(w-1.0)), clamped
  always_comb begin
    shade   = 23'd100 * 23'(w0 - 16'd256);
    green_c = (w0 < 16'd256) ? 8'd0 :
              ((shade[22:8] > 15'd255) ? 8'd255 : shade[15:8]);
  end

  // segment differences from the table read
  always_comb begin
    dx = $signed({b_x[31], b_x}) - $signed({a_x[31], a_x});
    dy = $signed({b_y[31], b_y}) - $signed({a_y[31], a_y});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 0: table read lands in the node table, width follows
      w0 <= s_tdata[147:132];
      // stage 1: differences and magnitudes
      adx1       <= dx[32] ? 32'(-dx) : dx[31:0];
      ady1       <= dy[32] ? 32'(-dy) : dy[31:0];
      w1         <= w0;
      c1.px      <= $signed(a_x);
      c1.py      <= $signed(a_y);
      c1.qx      <= $signed(b_x);
      c1.qy      <= $signed(b_y);
      c1.pz      <= a_z;
      c1.qz      <= b_z;
      c1.green   <= green_c;
      c1.negx    <= dy[32];
      c1.negy    <= !dx[32] && (dx != 33'sd0);
      c1.zero    <= (dx == 33'sd0) && (dy == 33'sd0);
      // stage 2: squares
      adx2 <= 64'(adx1) * 64'(adx1);
      ady2 <= 64'(ady1) * 64'(ady1);
      ww2  <= 32'(w1) * 32'(w1);
      c2   <= c1;
      // stage 3: sum of squares and partial products of 4*w*w*num*num
      sq3   <= 66'(adx2) + 66'(ady2);
      px_lo <= 64'(ww2) * 64'(ady2[31:0]);
      px_hi <= 64'(ww2) * 64'(ady2[63:32]);
      py_lo <= 64'(ww2) * 64'(adx2[31:0]);
      py_hi <= 64'(ww2) * 64'(adx2[63:32]);
      c3    <= c2;
      // stage 4: assemble the search bounds
      s4.lx.t <= (sqe_pkg::WW'(px_hi) << 34) + (sqe_pkg::WW'(px_lo) << 2);
      s4.ly.t <= (sqe_pkg::WW'(py_hi) << 34) + (sqe_pkg::WW'(py_lo) << 2);
      s4.lx.p <= '0;
      s4.lx.r <= '0;
      s4.lx.k <= '0;
      s4.ly.p <= '0;
      s4.ly.r <= '0;
      s4.ly.k <= '0;
      s4.sq   <= sq3;
      s4.c    <= c3;
    end
  end

  assign chain_d[0] = s4;
  assign chain_v[0] = v4;

  // one result bit per stage, msb first
  for (genvar g = 0; g < sqe_pkg::ROOT_STEPS; g++) begin : g_root
    sqe_root_step u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .bit_pos   (5'(sqe_pkg::ROOT_STEPS - 1 - g)),
      .in_valid  (chain_v[g]),
      .in_data   (chain_d[g]),
      .out_valid (chain_v[g + 1]),
      .out_data  (chain_d[g + 1])
    );
  end

  sqe_corner_ser u_ser (
    .clk      (clk),
    .rst      (rst),
    .in_valid (chain_v[sqe_pkg::ROOT_STEPS]),
    .in_data  (chain_d[sqe_pkg::ROOT_STEPS]),
    .can_load (can_load),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ----- hdl/sqe_node_table.sv -----
// node table: one write port, two registered read ports
module sqe_node_table (
  input  logic                         clk,
  input  logic                         en,
  input  logic                         wr,
  input  logic [sqe_pkg::IDX_W-1:0]    wr_idx,
  input  logic [31:0]                  wr_x,
  input  logic [31:0]                  wr_y,
  input  logic [31:0]                  wr_z,
  input  logic [sqe_pkg::IDX_W-1:0]    rd_a_idx,
  input  logic [sqe_pkg::IDX_W-1:0]    rd_b_idx,
  output logic [31:0]                  a_x,
  output logic [31:0]                  a_y,
  output logic [31:0]                  a_z,
  output logic [31:0]                  b_x,
  output logic [31:0]                  b_y,
  output logic [31:0]                  b_z
);

  logic [31:0] mem_x [sqe_pkg::NODE_DEPTH];
  logic [31:0] mem_y [sqe_pkg::NODE_DEPTH];
  logic [31:0] mem_z [sqe_pkg::NODE_DEPTH];
  logic [31:0] ra_x, ra_y, ra_z, rb_x, rb_y, rb_z;
  logic        oob_a, oob_b;
  logic [sqe_pkg::NODE_AW-1:0] wa, aa, ab;

  assign wa = sqe_pkg::NODE_AW'(wr_idx);
  assign aa = sqe_pkg::NODE_AW'(rd_a_idx);
  assign ab = sqe_pkg::NODE_AW'(rd_b_idx);

  always_ff @(posedge clk) begin
    if (wr && (32'(wr_idx) < 32'(sqe_pkg::NODE_DEPTH))) begin
      mem_x[wa] <= wr_x;
      mem_y[wa] <= wr_y;
      mem_z[wa] <= wr_z;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ra_x  <= mem_x[aa];
      ra_y  <= mem_y[aa];
      ra_z  <= mem_z[aa];
      rb_x  <= mem_x[ab];
      rb_y  <= mem_y[ab];
      rb_z  <= mem_z[ab];
      oob_a <= !(32'(rd_a_idx) < 32'(sqe_pkg::NODE_DEPTH));
      oob_b <= !(32'(rd_b_idx) < 32'(sqe_pkg::NODE_DEPTH));
    end
  end

  // entries beyond the table read as zero
  assign a_x = oob_a ? 32'd0 : ra_x;
  assign a_y = oob_a ? 32'd0 : ra_y;
  assign a_z = oob_a ? 32'd0 : ra_z;
  assign b_x = oob_b ? 32'd0 : rb_x;
  assign b_y = oob_b ? 32'd0 : rb_y;
  assign b_z = oob_b ? 32'd0 : rb_z;

endmodule

// ----- hdl/sqe_root_step.sv -----
// one pipelined step of the offset magnitude search, both lanes
module sqe_root_step (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  logic [4:0]      bit_pos,
  input  logic            in_valid,
  input  sqe_pkg::step_t  in_data,
  output logic            out_valid,
  output sqe_pkg::step_t  out_data
);

  function automatic sqe_pkg::lane_t lane_step(sqe_pkg::lane_t l, logic [65:0] sq,
                                               logic [4:0] b);
    logic [sqe_pkg::WW-1:0] sqx;
    logic [sqe_pkg::WW-1:0] cand;
    sqx  = sqe_pkg::WW'(sq);
    cand = l.p + (l.r << (6'(b) + 6'd1)) + (sqx << {b, 1'b0});
    if (cand <= l.t) begin
      l.p = cand;
      l.r = l.r + (sqx << b);
      l.k = l.k | (sqe_pkg::KW'(1) << b);
    end
    return l;
  endfunction

  sqe_pkg::step_t nxt;

  always_comb begin
    nxt    = in_data;
    nxt.lx = lane_step(in_data.lx, in_data.sq, bit_pos);
    nxt.ly = lane_step(in_data.ly, in_data.sq, bit_pos);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= nxt;
    end
  end

endmodule

// ----- hdl/sqe_corner_ser.sv -----
// corner builder and four-transfer output serializer
module sqe_corner_ser (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  sqe_pkg::step_t             in_data,
  output logic                       can_load,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [sqe_pkg::OUT_W-1:0]  m_tdata,
  output logic                       m_tlast
);

  function automatic logic [31:0] sat32(logic signed [33:0] v);
    if (v > 34'sd2147483647)       return 32'h7fffffff;
    else if (v < -34'sd2147483648) return 32'h80000000;
    else                           return v[31:0];
  endfunction

  logic              busy;
  logic [1:0]        cnt;
  logic [31:0]       cx [4];
  logic [31:0]       cy [4];
  logic [31:0]       cz [4];
  logic [7:0]        green;
  logic              load, xfer;
  logic signed [17:0] ox, oy, mx, my;
  logic signed [33:0] ex, ey;

  assign xfer     = busy && m_tready;
  assign can_load = !busy || (m_tready && (cnt == 2'd3));
  assign load     = in_valid && can_load;

  always_comb begin
    mx = in_data.c.zero ? 18'sd0 : $signed({1'b0, in_data.lx.k});
    my = in_data.c.zero ? 18'sd0 : $signed({1'b0, in_data.ly.k});
    ox = in_data.c.negx ? -mx : mx;
    oy = in_data.c.negy ? -my : my;
    ex = 34'(ox);
    ey = 34'(oy);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 2'd0;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= 2'd0;
    end else if (xfer) begin
      cnt <= cnt + 2'd1;
      if (cnt == 2'd3) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cx[0] <= sat32(34'(in_data.c.px) - ex);
      cx[1] <= sat32(34'(in_data.c.px) + ex);
      cx[2] <= sat32(34'(in_data.c.qx) - ex);
      cx[3] <= sat32(34'(in_data.c.qx) + ex);
      cy[0] <= sat32(34'(in_data.c.py) - ey);
      cy[1] <= sat32(34'(in_data.c.py) + ey);
      cy[2] <= sat32(34'(in_data.c.qy) - ey);
      cy[3] <= sat32(34'(in_data.c.qy) + ey);
      cz[0] <= in_data.c.pz;
      cz[1] <= in_data.c.pz;
      cz[2] <= in_data.c.qz;
      cz[3] <= in_data.c.qz;
      green <= in_data.c.green;
    end
  end

  assign m_tvalid = busy;
  assign m_tlast  = (cnt == 2'd3);
  assign m_tdata  = {6'd0, cnt, green, cz[cnt], cy[cnt], cx[cnt]};

endmodule

// ----- tb/tb_segment_to_quad_expander_unit.sv -----
// quad expander testbench: directed and random node stores and edges, corners checked in order
`timescale 1ns / 100ps

module tb_segment_to_quad_expander_unit;

  // one expected corner of a quad
  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [7:0]  green;
    logic [1:0]  num;
    logic        last;
  } corner_t;

  // keeps its own node table and the corners still to come
  class quad_scoreboard;
    logic [31:0] node_x [sqe_pkg::NODE_DEPTH];
    logic [31:0] node_y [sqe_pkg::NODE_DEPTH];
    logic [31:0] node_z [sqe_pkg::NODE_DEPTH];
    corner_t     pending_corners[$];
    int          errors;

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    // largest k in 0..2w with k * sqrt(sq) <= 2*w*num
    function automatic longint unsigned offset_mag(longint unsigned num, longint unsigned w,
                                                   logic [127:0] sq);
      logic [127:0] a;
      logic [127:0] a2;
      logic [127:0] m;
      longint unsigned lo;
      longint unsigned hi;
      longint unsigned mid;
      a = 128'(2 * w) * 128'(num);
      a2 = a * a;
      lo = 0;
      hi = 2 * w;
      if (num == 0) return 0;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        m = 128'(mid) * 128'(mid);
        if (sq * m <= a2) lo = mid;
        else hi = mid - 1;
      end
      return lo;
    endfunction

    function automatic logic [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'h7fff_ffff;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
    endfunction

    // an accepted input transfer: store a node or expand an edge into four corners
    function void note_input(logic act, logic [sqe_pkg::IN_W-1:0] d);
      logic [11:0] idx, ea, eb;
      longint px, py, qx, qy, dx, dy, ox, oy, bx, by;
      longint unsigned w, adx, ady, g;
      logic [127:0] sq;
      corner_t c;
      idx = d[11:0];
      ea  = d[119:108];
      eb  = d[131:120];
      w   = d[147:132];
      if (act == sqe_pkg::ACT_STORE) begin
        node_x[idx] = d[43:12];
        node_y[idx] = d[75:44];
        node_z[idx] = d[107:76];
        return;
      end
      px = longint'($signed(node_x[ea]));
      py = longint'($signed(node_y[ea]));
      qx = longint'($signed(node_x[eb]));
      qy = longint'($signed(node_y[eb]));
      dx = qx - px;
      dy = qy - py;
      adx = dx < 0 ? -dx : dx;
      ady = dy < 0 ? -dy : dy;
      sq = 128'(adx) * 128'(adx) + 128'(ady) * 128'(ady);
      if (adx == 0 && ady == 0) begin
        // zero-length segment gives no offset
        ox = 0;
        oy = 0;
      end else begin
        ox = longint'(offset_mag(ady, w, sq));
        oy = longint'(offset_mag(adx, w, sq));
        if (dy < 0) ox = -ox;
        if (dx > 0) oy = -oy;
      end
      if (w >= 256) begin
        g = (100 * (w - 256)) >> 8;
        if (g > 255) g = 255;
      end else begin
        g = 0;
      end
      for (int k = 0; k < 4; k++) begin
        bx = k < 2 ? px : qx;
        by = k < 2 ? py : qy;
        c.x = clamp32((k & 1) ? bx + ox : bx - ox);
        c.y = clamp32((k & 1) ? by + oy : by - oy);
        c.z = k < 2 ? node_z[ea] : node_z[eb];
        c.green = g[7:0];
        c.num = k[1:0];
        c.last = (k == 3);
        pending_corners.push_back(c);
      end
    endfunction

    task check_corner(logic [sqe_pkg::OUT_W-1:0] d, logic last);
      corner_t c;
      if (pending_corners.size() == 0) begin
        report($sformatf("unexpected corner %h", d));
        return;
      end
      c = pending_corners.pop_front();
      if (d[31:0] !== c.x) report($sformatf("corner_x %h exp %h", d[31:0], c.x));
      if (d[63:32] !== c.y) report($sformatf("corner_y %h exp %h", d[63:32], c.y));
      if (d[95:64] !== c.z) report($sformatf("corner_z %h exp %h", d[95:64], c.z));
      if (d[103:96] !== c.green) report($sformatf("green %0d exp %0d", d[103:96], c.green));
      if (d[105:104] !== c.num) report($sformatf("corner_number %0d exp %0d",
                                                 d[105:104], c.num));
      if (last !== c.last) report($sformatf("last_corner %b exp %b", last, c.last));
    endtask
  endclass

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      s_tvalid = 1'b0;
  logic                      s_tready;
  logic [sqe_pkg::IN_W-1:0]  s_tdata = '0;
  logic                      s_tuser = sqe_pkg::ACT_STORE;
  logic                      m_tvalid;
  logic                      m_tready = 1'b0;
  logic [sqe_pkg::OUT_W-1:0] m_tdata;
  logic                      m_tlast;

  quad_scoreboard sb = new();
  logic [11:0]    written_nodes[$];
  int             hold_request = 0;
  int unsigned    cycle_count = 0;

  segment_to_quad_expander_unit dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 600000) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // input side: every accepted transfer goes to the predictor
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) sb.note_input(s_tuser, s_tdata);
  end

  // output side: every accepted corner is checked against the oldest expectation
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_corner(m_tdata, m_tlast);
  end

  // receiver readiness: random stalls, plus a long hold-off on request
  always @(posedge clk) begin
    int hold_left;
    if (rst) begin
      m_tready <= 1'b0;
      hold_left = 0;
    end else if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      case ($urandom_range(0, 19))
        0:       hold_left = $urandom_range(10, 40);   // rare long stall
        1, 2, 3: hold_left = $urandom_range(0, 3);
        default: hold_left = 0;
      endcase
      m_tready <= (hold_left == 0);
    end
  end

  // short random gap before the next transfer, sometimes long, often none
  task idle_gap(bit allow_gap);
    int n;
    n = 0;
    if (allow_gap) begin
      case ($urandom_range(0, 15))
        0:          n = $urandom_range(8, 30);
        1, 2, 3, 4: n = $urandom_range(1, 3);
        default:    n = 0;
      endcase
    end
    if (n > 0) begin
      s_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // offer one transfer and wait for its handshake
  task send_item(logic act, logic [11:0] idx, logic [31:0] x, logic [31:0] y,
                 logic [31:0] z, logic [11:0] ea, logic [11:0] eb, logic [15:0] w,
                 bit allow_gap);
    idle_gap(allow_gap);
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {4'b0, w, eb, ea, z, y, x, idx};
    do @(posedge clk); while (!s_tready);
    if (act == sqe_pkg::ACT_STORE) written_nodes.push_back(idx);
  endtask

  task store_node(logic [11:0] idx, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                  bit allow_gap);
    send_item(sqe_pkg::ACT_STORE, idx, x, y, z, 12'($urandom), 12'($urandom),
              16'($urandom), allow_gap);
  endtask

  task expand_edge(logic [11:0] ea, logic [11:0] eb, logic [15:0] w, bit allow_gap);
    send_item(sqe_pkg::ACT_EDGE, 12'($urandom), $urandom, $urandom, $urandom, ea, eb, w,
              allow_gap);
  endtask

  function automatic logic [31:0] random_coord();
    case ($urandom_range(0, 5))
      0:       return $urandom;                        // full range, corners may saturate
      1:       return $urandom_range(0, 1) ? 32'h7fff_fff0 + $urandom_range(0, 15)
                                           : 32'h8000_0000 + $urandom_range(0, 15);
      default: return 32'($signed($urandom_range(0, 200000)) - 100000);
    endcase
  endfunction

  function automatic logic [15:0] random_width();
    case ($urandom_range(0, 3))
      0:       return 16'($urandom);
      1:       return 16'($urandom_range(0, 300));
      default: return 16'($urandom_range(256, 1200));
    endcase
  endfunction

  initial begin
    logic [11:0] a, b;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extreme indices and coordinates
    store_node(12'd0, 32'h0000_0000, 32'h0000_0000, 32'hffff_ffff, 0);
    store_node(12'd4095, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 0);
    store_node(12'd1, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 0);
    store_node(12'd2, 32'h0000_0a00, 32'h0000_0000, 32'h0000_0100, 0);
    store_node(12'd3, 32'h0000_0000, 32'hffff_f600, 32'h1234_5678, 0);
    store_node(12'd2730, 32'h0000_0300, 32'h0000_0400, 32'h0, 0);
    expand_edge(12'd0, 12'd2, 16'h0100, 0);     // horizontal, width one, green zero
    expand_edge(12'd0, 12'd3, 16'h0280, 0);     // vertical
    expand_edge(12'd2, 12'd0, 16'h00ff, 0);     // reversed, narrow width
    expand_edge(12'd2730, 12'd2730, 16'h0400, 0); // zero-length segment
    expand_edge(12'd0, 12'd2730, 16'h0000, 0);  // zero width
    expand_edge(12'd0, 12'd2730, 16'hffff, 0);  // widest, green saturates
    expand_edge(12'd1, 12'd4095, 16'hffff, 0);  // full diagonal, corners saturate
    expand_edge(12'd4095, 12'd1, 16'h0300, 0);
    expand_edge(12'd4095, 12'd0, 16'h8000, 0);
    expand_edge(12'd3, 12'd2, 16'h0400, 0);
    expand_edge(12'd1, 12'd0, 16'h7fff, 0);
    expand_edge(12'd2, 12'd3, 16'h03a0, 0);

    // random part; early on the receiver holds off while the sender keeps offering
    for (int i = 0; i < 470; i++) begin
      if (i == 40) hold_request = 400;
      if ($urandom_range(0, 9) < 3 || written_nodes.size() < 4) begin
        store_node($urandom_range(0, 1) ? 12'($urandom)
                                        : written_nodes[$urandom_range(0, written_nodes.size()-1)],
                   random_coord(), random_coord(), $urandom, i > 60);
      end else begin
        a = written_nodes[$urandom_range(0, written_nodes.size() - 1)];
        b = $urandom_range(0, 9) == 0 ? a
          : written_nodes[$urandom_range(0, written_nodes.size() - 1)];
        expand_edge(a, b, random_width(), i > 60);
      end
    end
    s_tvalid <= 1'b0;

    while (sb.pending_corners.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
